FILE: hdl/ahcfe_pkg.sv
// shared types, codes and helpers for the ascii hex command frame encoder
// no dependencies; frame control, emitter, output register and top level import this package
package ahcfe_pkg;

  // line characters
  localparam logic [7:0] SOI_CHAR   = 8'h7E;
  localparam logic [7:0] EOI_CHAR   = 8'h0D;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] NOTICE_CHAR = 8'h00;

  // saturation limit of the char counter
  localparam logic [11:0] COUNT_MAX = 12'hFFF;

  // configuration register indexes
  localparam logic REG_VERSION = 1'b0;
  localparam logic REG_DEVTYPE = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] VERSION_RESET = 8'h21;
  localparam logic [7:0] DEVTYPE_RESET = 8'h2A;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_DROP     = 2'd1;
  localparam status_t ST_MISMATCH = 2'd2;

  // output slots of one item, in line order
  typedef logic [4:0] slot_t;
  localparam slot_t SL_SOI     = 5'd0;
  localparam slot_t SL_VER_HI  = 5'd1;
  localparam slot_t SL_VER_LO  = 5'd2;
  localparam slot_t SL_ADR_HI  = 5'd3;
  localparam slot_t SL_ADR_LO  = 5'd4;
  localparam slot_t SL_DEV_HI  = 5'd5;
  localparam slot_t SL_DEV_LO  = 5'd6;
  localparam slot_t SL_CMD_HI  = 5'd7;
  localparam slot_t SL_CMD_LO  = 5'd8;
  localparam slot_t SL_LEN_3   = 5'd9;
  localparam slot_t SL_LEN_2   = 5'd10;
  localparam slot_t SL_LEN_1   = 5'd11;
  localparam slot_t SL_LEN_0   = 5'd12;
  localparam slot_t SL_CHAR    = 5'd13;
  localparam slot_t SL_CHK_3   = 5'd14;
  localparam slot_t SL_CHK_2   = 5'd15;
  localparam slot_t SL_CHK_1   = 5'd16;
  localparam slot_t SL_CHK_0   = 5'd17;
  localparam slot_t SL_EOI     = 5'd18;
  localparam slot_t SL_NOTICE  = 5'd19;

  // decoded item handed from frame control to the emitter
  typedef struct packed {
    logic [7:0]  info_char;
    logic [7:0]  frame_addr;
    logic [7:0]  command_id;
    logic [11:0] info_count;
    logic        hdr;       // full header goes out
    logic        notice;    // odd count, drop notice only
    logic        char_en;   // info char goes out
    logic        trl;       // checksum and eoi go out
    logic        mismatch;  // chars seen differ from declared count
  } item_t;

  // one result byte with its flags
  typedef struct packed {
    logic [7:0] out_char;
    logic       frame_end;
    status_t    status;
  } res_t;

  // uppercase ascii hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h37 + {4'd0, v};
    end
    return r;
  endfunction

endpackage

FILE: hdl/ahcfe_in_if.sv
// input channel of the frame encoder: valid/ready plus one info item
// depends on nothing
interface ahcfe_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  info_char;
  logic        first_char;
  logic        last_char;
  logic [7:0]  frame_addr;
  logic [7:0]  command_id;
  logic [11:0] info_count;

  modport source (
    output valid, info_char, first_char, last_char, frame_addr, command_id, info_count,
    input  ready
  );
  modport sink (
    input  valid, info_char, first_char, last_char, frame_addr, command_id, info_count,
    output ready
  );
endinterface

FILE: hdl/ahcfe_out_if.sv
// output channel of the frame encoder: valid/ready plus one frame byte
// depends on nothing
interface ahcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       frame_end;
  logic [1:0] status;

  modport source (
    output valid, out_char, frame_end, status,
    input  ready
  );
  modport sink (
    input  valid, out_char, frame_end, status,
    output ready
  );
endinterface

FILE: hdl/ahcfe_frame_ctl.sv
// frame tracking: open/drop state, declared count and seen count per transfer
// depends on ahcfe_pkg; decodes each accepted item into an item_t
module ahcfe_frame_ctl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          info_char,
  input  logic                first_char,
  input  logic                last_char,
  input  logic [7:0]          frame_addr,
  input  logic [7:0]          command_id,
  input  logic [11:0]         info_count,
  output ahcfe_pkg::item_t    item
);
  import ahcfe_pkg::*;

  logic        in_frame;
  logic        drop_frame;
  logic [11:0] chars_seen;
  logic [11:0] declared_count;

  logic        frame_next;
  logic        drop_next;
  logic [11:0] declared_next;
  logic [11:0] seen_base;
  logic [11:0] chars_seen_next;
  logic        active;
  logic        char_en;

  // frame state as seen by this item
  always_comb begin
    frame_next    = first_char ? 1'b1 : in_frame;
    drop_next     = first_char ? info_count[0] : drop_frame;
    declared_next = first_char ? info_count : declared_count;
    seen_base     = first_char ? 12'd0 : chars_seen;
    active        = frame_next && !drop_next;
    char_en       = active && (info_char != SPACE_CHAR);
    if (char_en && (seen_base != COUNT_MAX)) begin
      chars_seen_next = seen_base + 12'd1;
    end else begin
      chars_seen_next = seen_base;
    end
  end

  // decoded item
  always_comb begin
    item.info_char  = info_char;
    item.frame_addr = frame_addr;
    item.command_id = command_id;
    item.info_count = info_count;
    item.hdr        = first_char && !info_count[0];
    item.notice     = first_char && info_count[0];
    item.char_en    = char_en;
    item.trl        = active && last_char;
    item.mismatch   = chars_seen_next != declared_next;
  end

  // state update per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      drop_frame     <= 1'b0;
      chars_seen     <= 12'd0;
      declared_count <= 12'd0;
    end else if (accept) begin
      in_frame       <= last_char ? 1'b0 : frame_next;
      drop_frame     <= last_char ? 1'b0 : drop_next;
      chars_seen     <= chars_seen_next;
      declared_count <= declared_next;
    end
  end

endmodule

FILE: hdl/ahcfe_emit.sv
// item register and byte sequencer: walks the output slots of one item,
// keeps the running body sum; depends on ahcfe_pkg
module ahcfe_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  ahcfe_pkg::item_t    ld_item,
  input  logic [7:0]          protocol_version,
  input  logic [7:0]          device_type,
  input  logic                out_take,
  output logic                in_ready,
  output logic                fire,
  output ahcfe_pkg::res_t     res
);
  import ahcfe_pkg::*;

  logic        busy;
  slot_t       slot;
  item_t       item;
  logic [15:0] running_sum;

  slot_t       slot_next;
  logic        slot_last;
  slot_t       first_slot;
  logic        first_any;
  logic [3:0]  len_chk;
  logic [15:0] len_word;
  logic [15:0] chk_word;
  logic        body;

  // next active slot of the held item
  always_comb begin
    slot_next = slot + 5'd1;
    slot_last = 1'b0;
    case (slot)
      SL_LEN_0: begin
        if (item.char_en) begin
          slot_next = SL_CHAR;
        end else if (item.trl) begin
          slot_next = SL_CHK_3;
        end else begin
          slot_last = 1'b1;
        end
      end
      SL_CHAR: begin
        if (item.trl) begin
          slot_next = SL_CHK_3;
        end else begin
          slot_last = 1'b1;
        end
      end
      SL_EOI:    slot_last = 1'b1;
      SL_NOTICE: slot_last = 1'b1;
      default:   slot_last = 1'b0;
    endcase
  end

  // first slot of a freshly loaded item
  always_comb begin
    first_any  = 1'b1;
    first_slot = SL_SOI;
    if (ld_item.notice) begin
      first_slot = SL_NOTICE;
    end else if (ld_item.hdr) begin
      first_slot = SL_SOI;
    end else if (ld_item.char_en) begin
      first_slot = SL_CHAR;
    end else if (ld_item.trl) begin
      first_slot = SL_CHK_3;
    end else begin
      first_any = 1'b0;
    end
  end

  assign fire     = busy && out_take;
  assign in_ready = !busy || (fire && slot_last);

  // length word and checksum
  always_comb begin
    len_chk  = 4'd0 - (item.info_count[11:8] + item.info_count[7:4] + item.info_count[3:0]);
    len_word = {len_chk, item.info_count};
    chk_word = 16'd0 - running_sum;
  end

  // byte for the current slot
  always_comb begin
    res.frame_end = 1'b0;
    res.status    = ST_OK;
    body          = 1'b1;
    case (slot)
      SL_SOI: begin
        res.out_char = SOI_CHAR;
        body         = 1'b0;
      end
      SL_VER_HI: res.out_char = hex_char(protocol_version[7:4]);
      SL_VER_LO: res.out_char = hex_char(protocol_version[3:0]);
      SL_ADR_HI: res.out_char = hex_char(item.frame_addr[7:4]);
      SL_ADR_LO: res.out_char = hex_char(item.frame_addr[3:0]);
      SL_DEV_HI: res.out_char = hex_char(device_type[7:4]);
      SL_DEV_LO: res.out_char = hex_char(device_type[3:0]);
      SL_CMD_HI: res.out_char = hex_char(item.command_id[7:4]);
      SL_CMD_LO: res.out_char = hex_char(item.command_id[3:0]);
      SL_LEN_3:  res.out_char = hex_char(len_word[15:12]);
      SL_LEN_2:  res.out_char = hex_char(len_word[11:8]);
      SL_LEN_1:  res.out_char = hex_char(len_word[7:4]);
      SL_LEN_0:  res.out_char = hex_char(len_word[3:0]);
      SL_CHAR:   res.out_char = item.info_char;
      SL_CHK_3: begin
        res.out_char = hex_char(chk_word[15:12]);
        body         = 1'b0;
      end
      SL_CHK_2: begin
        res.out_char = hex_char(chk_word[11:8]);
        body         = 1'b0;
      end
      SL_CHK_1: begin
        res.out_char = hex_char(chk_word[7:4]);
        body         = 1'b0;
      end
      SL_CHK_0: begin
        res.out_char = hex_char(chk_word[3:0]);
        body         = 1'b0;
      end
      SL_EOI: begin
        res.out_char  = EOI_CHAR;
        res.frame_end = 1'b1;
        res.status    = item.mismatch ? ST_MISMATCH : ST_OK;
        body          = 1'b0;
      end
      SL_NOTICE: begin
        res.out_char  = NOTICE_CHAR;
        res.frame_end = 1'b1;
        res.status    = ST_DROP;
        body          = 1'b0;
      end
      default: begin
        res.out_char = NOTICE_CHAR;
        body         = 1'b0;
      end
    endcase
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= SL_SOI;
    end else if (accept) begin
      busy <= first_any;
      slot <= first_slot;
    end else if (fire) begin
      if (slot_last) begin
        busy <= 1'b0;
      end else begin
        slot <= slot_next;
      end
    end
  end

  // held item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= ld_item;
    end
  end

  // running body sum, cleared when a new frame opens
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 16'd0;
    end else if (accept && (ld_item.hdr || ld_item.notice)) begin
      running_sum <= 16'd0;
    end else if (fire && body) begin
      running_sum <= running_sum + {8'd0, res.out_char};
    end
  end

endmodule

FILE: hdl/ahcfe_out_reg.sv
// output register: holds one result byte until the receiver takes it
// depends on ahcfe_pkg and ahcfe_out_if
module ahcfe_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  ahcfe_pkg::res_t    res,
  output logic               out_take,
  ahcfe_out_if.source        result_out
);
  import ahcfe_pkg::*;

  logic valid;
  res_t data;

  // free when empty or being drained this cycle
  assign out_take = !valid || result_out.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_take) begin
      valid <= fire;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (fire && out_take) begin
      data <= res;
    end
  end

  assign result_out.valid     = valid;
  assign result_out.out_char  = data.out_char;
  assign result_out.frame_end = data.frame_end;
  assign result_out.status    = data.status;

endmodule

FILE: hdl/ascii_hex_command_frame_encoder.sv
// top level of the ascii hex command frame encoder
// depends on ahcfe_pkg, ahcfe_in_if, ahcfe_out_if, ahcfe_frame_ctl, ahcfe_emit, ahcfe_out_reg
//
// Usage:
//   item_in carries one info char per transfer; the transfer with first_char
//   also carries frame_addr, command_id and info_count. result_out carries
//   frame bytes, one per transfer, with frame_end and status on the eoi byte
//   or on the single drop notice of an odd-count frame.
//   cfg_we/cfg_index/cfg_data write protocol_version (index 0) and
//   device_type (index 1); write them only while the block is idle.
// Timing:
//   each accepted item is held in the sequencer, which issues one byte per
//   cycle into the output register while that register can take it; each
//   byte is registered there before it is valid. Plain info chars stream at
//   one per cycle when the output does not stall. A first item of an even
//   count adds the header (soi to length), the last item of a kept frame adds
//   checksum and eoi; item_in.ready stays low during those bursts.
// Reset and stall:
//   rst (synchronous) closes any open frame, empties the output register and
//   restores the register defaults. While a byte is held and result_out.ready
//   is low, that byte holds and the sequencer waits, so item_in.ready drops
//   once the held item has bytes left.
module ascii_hex_command_frame_encoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  ahcfe_in_if.sink      item_in,
  ahcfe_out_if.source   result_out
);
  import ahcfe_pkg::*;

  logic [7:0] protocol_version;
  logic [7:0] device_type;
  logic       accept;
  logic       in_ready;
  logic       fire;
  logic       out_take;
  item_t      ld_item;
  res_t       res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= VERSION_RESET;
      device_type      <= DEVTYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERSION: protocol_version <= cfg_data;
        REG_DEVTYPE: device_type      <= cfg_data;
        default:     protocol_version <= protocol_version;
      endcase
    end
  end

  // input transfer
  assign item_in.ready = in_ready;
  assign accept        = item_in.valid && in_ready;

  ahcfe_frame_ctl u_frame_ctl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .info_char  (item_in.info_char),
    .first_char (item_in.first_char),
    .last_char  (item_in.last_char),
    .frame_addr (item_in.frame_addr),
    .command_id (item_in.command_id),
    .info_count (item_in.info_count),
    .item       (ld_item)
  );

  ahcfe_emit u_emit (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .ld_item          (ld_item),
    .protocol_version (protocol_version),
    .device_type      (device_type),
    .out_take         (out_take),
    .in_ready         (in_ready),
    .fire             (fire),
    .res              (res)
  );

  ahcfe_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .res        (res),
    .out_take   (out_take),
    .result_out (result_out)
  );

endmodule
